// ===== hw/rtl/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helper functions of the integer-to-ASCII
// digit formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // Field widths
    localparam int VALUE_IN_W  = 32;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 5;
    localparam int CHAR_W      = 7;
    localparam int POS_W       = 4;
    localparam int NIB_W       = 4;
    localparam int MAX_CHARS   = 16;

    // Digit limits per radix
    localparam int DEC_DIGITS  = 10;
    localparam int HEX_DIGITS  = 8;
    localparam int BIN_DIGITS  = 16;
    localparam int BCD_W       = DEC_DIGITS * NIB_W;

    // Value bits folded into the BCD register per pipeline stage
    localparam int DABBLE_BITS = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } mode_t;

    typedef logic [BCD_W-1:0]  bcd_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [MAX_CHARS-1:0] char_row_t;

    // Per-item control carried down the pipeline
    typedef struct packed {
        mode_t            mode;
        logic [LEN_W-1:0] len;
        logic             neg;
    } item_ctrl_t;

    // Map one digit value to its upper-case ASCII character
    function automatic char_t digit_char(input logic [NIB_W-1:0] d);
        char_t c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = ASCII_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

    // One shift-and-add-3 step: double the BCD value and add the new bit,
    // dropping any carry out of the top digit
    function automatic bcd_t dabble_step(input bcd_t b, input logic b_in);
        bcd_t t;
        t = b;
        for (int j = 0; j < DEC_DIGITS; j++)
        begin
            if (t[j*NIB_W +: NIB_W] >= 4'd5)
            begin
                t[j*NIB_W +: NIB_W] = t[j*NIB_W +: NIB_W] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], b_in};
    endfunction

endpackage

// ===== hw/rtl/i2a_in_if.sv =====
// ----------------------------------------------------------------------------
// i2a_in_if
// Number channel: one item is a value with its mode and digit count.
// ----------------------------------------------------------------------------
interface i2a_in_if;

    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic [i2a_pkg::VALUE_IN_W-1:0]  value;
    logic [i2a_pkg::LEN_W-1:0]       length;

    modport source
    (
        output valid,
        output mode,
        output value,
        output length,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  mode,
        input  value,
        input  length,
        output ready
    );

endinterface

// ===== hw/rtl/i2a_out_if.sv =====
// ----------------------------------------------------------------------------
// i2a_out_if
// Character channel: one item is one ASCII character with its column.
// ----------------------------------------------------------------------------
interface i2a_out_if;

    logic                        valid;
    logic                        ready;
    logic [i2a_pkg::CHAR_W-1:0]  char_code;
    logic [i2a_pkg::POS_W-1:0]   position;
    logic                        last;

    modport source
    (
        output valid,
        output char_code,
        output position,
        output last,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  char_code,
        input  position,
        input  last,
        output ready
    );

endinterface

// ===== hw/rtl/i2a_prep.sv =====
// ----------------------------------------------------------------------------
// i2a_prep
// First pipeline stage: clamp the digit count, take the sign in signed
// decimal mode and form the magnitude.
// ----------------------------------------------------------------------------
module i2a_prep #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    i2a_in_if.sink                   src,
    output logic                     out_valid,
    input  logic                     out_ready,
    output i2a_pkg::item_ctrl_t      out_ctrl,
    output logic [VALUE_WIDTH-1:0]   out_mag
);

    logic                           valid_reg;
    logic                           valid_next;
    i2a_pkg::item_ctrl_t            ctrl_reg;
    i2a_pkg::item_ctrl_t            ctrl_next;
    logic [VALUE_WIDTH-1:0]         mag_reg;
    logic [VALUE_WIDTH-1:0]         mag_next;

    logic                           load;
    i2a_pkg::mode_t                 mode_e;
    logic [VALUE_WIDTH-1:0]         v;
    logic [i2a_pkg::LEN_W-1:0]      max_len;

    // Advance when the stage is empty or its item moves on
    assign src.ready = !valid_reg || out_ready;
    assign load      = src.valid && src.ready;

    assign mode_e = i2a_pkg::mode_t'(src.mode);
    assign v      = VALUE_WIDTH'(src.value);

    // Pick the digit limit of the radix
    always_comb
    begin
        case (mode_e)
            i2a_pkg::MODE_HEX: max_len = i2a_pkg::LEN_W'(i2a_pkg::HEX_DIGITS);
            i2a_pkg::MODE_BIN: max_len = i2a_pkg::LEN_W'(i2a_pkg::BIN_DIGITS);
            default:           max_len = i2a_pkg::LEN_W'(i2a_pkg::DEC_DIGITS);
        endcase
    end

    // Clamp the length and negate a negative signed value
    always_comb
    begin
        ctrl_next.mode = mode_e;
        ctrl_next.len  = (src.length > max_len) ? max_len : src.length;
        ctrl_next.neg  = (mode_e == i2a_pkg::MODE_SDEC) && v[VALUE_WIDTH-1];
        mag_next       = ctrl_next.neg ? ({VALUE_WIDTH{1'b0}} - v) : v;
    end

    assign valid_next = src.ready ? src.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= ctrl_next;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_mag   = mag_reg;

endmodule

// ===== hw/rtl/i2a_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// i2a_dabble_stage
// One binary-to-BCD pipeline stage: folds one byte of the magnitude, most
// significant first, into a ten-digit BCD register.
// ----------------------------------------------------------------------------
module i2a_dabble_stage #(
    parameter int VALUE_WIDTH = 32,
    parameter int STAGE       = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  i2a_pkg::item_ctrl_t      in_ctrl,
    input  logic [VALUE_WIDTH-1:0]   in_mag,
    input  i2a_pkg::bcd_t            in_bcd,
    output logic                     out_valid,
    input  logic                     out_ready,
    output i2a_pkg::item_ctrl_t      out_ctrl,
    output logic [VALUE_WIDTH-1:0]   out_mag,
    output i2a_pkg::bcd_t            out_bcd
);

    localparam int NUM_STAGES = (VALUE_WIDTH + i2a_pkg::DABBLE_BITS - 1) / i2a_pkg::DABBLE_BITS;
    localparam int PAD_W      = NUM_STAGES * i2a_pkg::DABBLE_BITS;
    localparam int TOP_BIT    = PAD_W - 1 - STAGE * i2a_pkg::DABBLE_BITS;

    logic                            valid_reg;
    logic                            valid_next;
    i2a_pkg::item_ctrl_t             ctrl_reg;
    logic [VALUE_WIDTH-1:0]          mag_reg;
    i2a_pkg::bcd_t                   bcd_reg;
    i2a_pkg::bcd_t                   bcd_next;

    logic                            load;
    logic [PAD_W-1:0]                mag_pad;
    logic [i2a_pkg::DABBLE_BITS-1:0] chunk;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Leading zero padding leaves the BCD value unchanged
    assign mag_pad = PAD_W'(in_mag);
    assign chunk   = mag_pad[TOP_BIT -: i2a_pkg::DABBLE_BITS];

    // Shift this stage's byte in, one bit per step
    always_comb
    begin
        bcd_next = in_bcd;
        for (int k = i2a_pkg::DABBLE_BITS - 1; k >= 0; k--)
        begin
            bcd_next = i2a_pkg::dabble_step(bcd_next, chunk[k]);
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg <= in_ctrl;
            mag_reg  <= in_mag;
            bcd_reg  <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_mag   = mag_reg;
    assign out_bcd   = bcd_reg;

endmodule

// ===== hw/rtl/i2a_assemble.sv =====
// ----------------------------------------------------------------------------
// i2a_assemble
// Pipeline stage that lays out the full character row of one number:
// optional sign, then the low 'length' digits of the chosen radix.
// ----------------------------------------------------------------------------
module i2a_assemble #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  i2a_pkg::item_ctrl_t        in_ctrl,
    input  logic [VALUE_WIDTH-1:0]     in_mag,
    input  i2a_pkg::bcd_t              in_bcd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output i2a_pkg::char_row_t         out_row,
    output logic [i2a_pkg::CNT_W-1:0]  out_cnt
);

    localparam int HEX_W = i2a_pkg::HEX_DIGITS * i2a_pkg::NIB_W;
    localparam int ROW_W = i2a_pkg::MAX_CHARS * i2a_pkg::NIB_W;

    logic                          valid_reg;
    logic                          valid_next;
    i2a_pkg::char_row_t            row_reg;
    i2a_pkg::char_row_t            row_next;
    logic [i2a_pkg::CNT_W-1:0]     cnt_reg;
    logic [i2a_pkg::CNT_W-1:0]     cnt_next;

    logic                          load;
    logic                          signed_mode;
    logic [HEX_W-1:0]              mag_lo;
    logic [ROW_W-1:0]              dec_nib;
    logic [ROW_W-1:0]              hex_nib;
    logic [ROW_W-1:0]              bin_nib;
    logic [ROW_W-1:0]              sel_nib;
    logic [i2a_pkg::POS_W-1:0]     idx;
    logic [i2a_pkg::POS_W-1:0]     dn;
    logic [i2a_pkg::NIB_W-1:0]     nib;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign signed_mode = (in_ctrl.mode == i2a_pkg::MODE_SDEC);
    assign mag_lo      = HEX_W'(in_mag);
    assign dec_nib     = ROW_W'(in_bcd);
    assign hex_nib     = ROW_W'(mag_lo);

    // Spread binary digits one per nibble
    always_comb
    begin
        for (int j = 0; j < i2a_pkg::BIN_DIGITS; j++)
        begin
            bin_nib[j*i2a_pkg::NIB_W +: i2a_pkg::NIB_W] = {3'b000, mag_lo[j]};
        end
    end

    // Select the digit source of the radix
    always_comb
    begin
        case (in_ctrl.mode)
            i2a_pkg::MODE_HEX: sel_nib = hex_nib;
            i2a_pkg::MODE_BIN: sel_nib = bin_nib;
            default:           sel_nib = dec_nib;
        endcase
    end

    // Fill each column: sign first in signed mode, then most significant digit
    always_comb
    begin
        idx = '0;
        dn  = '0;
        nib = '0;
        for (int k = 0; k < i2a_pkg::MAX_CHARS; k++)
        begin
            idx = i2a_pkg::POS_W'(k) - {3'b000, signed_mode};
            dn  = in_ctrl.len[i2a_pkg::POS_W-1:0] - 4'd1 - idx;
            nib = sel_nib[dn*i2a_pkg::NIB_W +: i2a_pkg::NIB_W];
            if (signed_mode && (k == 0))
            begin
                row_next[k] = in_ctrl.neg ? i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_PLUS;
            end
            else
            begin
                row_next[k] = i2a_pkg::digit_char(nib);
            end
        end
    end

    assign cnt_next   = in_ctrl.len + i2a_pkg::CNT_W'(signed_mode);
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= row_next;
            cnt_reg <= cnt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_row   = row_reg;
    assign out_cnt   = cnt_reg;

endmodule

// ===== hw/rtl/i2a_serial.sv =====
// ----------------------------------------------------------------------------
// i2a_serial
// Serialiser: holds one character row and sends one character per cycle,
// while the output is taken, through a registered output stage.
// ----------------------------------------------------------------------------
module i2a_serial (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  i2a_pkg::char_row_t         in_row,
    input  logic [i2a_pkg::CNT_W-1:0]  in_cnt,
    i2a_out_if.source                  dst
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [i2a_pkg::POS_W-1:0]     idx_reg;
    logic [i2a_pkg::POS_W-1:0]     idx_next;
    i2a_pkg::char_row_t            row_reg;
    logic [i2a_pkg::CNT_W-1:0]     cnt_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    i2a_pkg::char_t                char_reg;
    i2a_pkg::char_t                char_next;
    logic [i2a_pkg::POS_W-1:0]     pos_reg;
    logic [i2a_pkg::POS_W-1:0]     pos_next;
    logic                          last_reg;
    logic                          last_next;

    logic                          out_adv;
    logic                          emit;
    logic                          final_emit;
    logic                          load;

    // Output register frees when empty or taken
    assign out_adv    = !out_valid_reg || dst.ready;
    assign emit       = busy_reg && out_adv;
    assign final_emit = emit &&
                        (i2a_pkg::CNT_W'(idx_reg) == cnt_reg - i2a_pkg::CNT_W'(1));

    // Take the next row as the current one sends its final character
    assign in_ready = !busy_reg || final_emit;
    assign load     = in_valid && in_ready;

    // Sequence control; an empty row is dropped on load
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = (in_cnt != '0);
            idx_next  = '0;
        end
        else if (emit)
        begin
            busy_next = !final_emit;
            idx_next  = idx_reg + 4'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_adv ? emit : out_valid_reg;
        char_next      = row_reg[idx_reg];
        pos_next       = idx_reg;
        last_next      = final_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the row for the whole sequence
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg <= in_row;
            cnt_reg <= in_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            char_reg <= char_next;
            pos_reg  <= pos_next;
            last_reg <= last_next;
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.char_code = char_reg;
    assign dst.position  = pos_reg;
    assign dst.last      = last_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_digits
// Formats a number as fixed-width unsigned/signed decimal, hex or binary
// ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Path of a number: prep, one BCD stage per value byte, assemble,
// serialiser load and output register, each of them registered.
// Throughput: the pipeline takes one number per cycle unless stalled;
// the serialiser sends up to 16 characters of a number, one a cycle while
// the output is taken, and loads the next row as it sends the final one.
// Reset clears all valid bits and the serialiser; no clearing pass.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    i2a_in_if.sink      number,
    i2a_out_if.source   chars
);

    localparam int NUM_STAGES = (VALUE_WIDTH + i2a_pkg::DABBLE_BITS - 1) / i2a_pkg::DABBLE_BITS;

    logic                          st_valid [NUM_STAGES+1];
    logic                          st_ready [NUM_STAGES+1];
    i2a_pkg::item_ctrl_t           st_ctrl  [NUM_STAGES+1];
    logic [VALUE_WIDTH-1:0]        st_mag   [NUM_STAGES+1];
    i2a_pkg::bcd_t                 st_bcd   [NUM_STAGES+1];

    logic                          row_valid;
    logic                          row_ready;
    i2a_pkg::char_row_t            row;
    logic [i2a_pkg::CNT_W-1:0]     row_cnt;

    // Clamp, sign and magnitude
    i2a_prep #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (number),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_ctrl  (st_ctrl[0]),
        .out_mag   (st_mag[0])
    );

    assign st_bcd[0] = '0;

    // Binary to BCD, one byte per stage
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_dabble
        i2a_dabble_stage #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .STAGE       (s)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[s]),
            .in_ready  (st_ready[s]),
            .in_ctrl   (st_ctrl[s]),
            .in_mag    (st_mag[s]),
            .in_bcd    (st_bcd[s]),
            .out_valid (st_valid[s+1]),
            .out_ready (st_ready[s+1]),
            .out_ctrl  (st_ctrl[s+1]),
            .out_mag   (st_mag[s+1]),
            .out_bcd   (st_bcd[s+1])
        );
    end

    // Lay out the characters
    i2a_assemble #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[NUM_STAGES]),
        .in_ready  (st_ready[NUM_STAGES]),
        .in_ctrl   (st_ctrl[NUM_STAGES]),
        .in_mag    (st_mag[NUM_STAGES]),
        .in_bcd    (st_bcd[NUM_STAGES]),
        .out_valid (row_valid),
        .out_ready (row_ready),
        .out_row   (row),
        .out_cnt   (row_cnt)
    );

    // Send one character per cycle while the output is taken
    i2a_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (row_valid),
        .in_ready (row_ready),
        .in_row   (row),
        .in_cnt   (row_cnt),
        .dst      (chars)
    );

    // A taken character that is not the last is followed at once by the next column
    a_next_column : assert property (
        @(posedge clk) disable iff (!rst_n)
        chars.valid && chars.ready && !chars.last |=>
            chars.valid && (chars.position == 4'($past(chars.position) + 4'd1))
    ) else $error("character sequence broke before its last column");

    // A sign only ever opens a number
    a_sign_first : assert property (
        @(posedge clk) disable iff (!rst_n)
        chars.valid && ((chars.char_code == i2a_pkg::ASCII_PLUS) ||
                        (chars.char_code == i2a_pkg::ASCII_MINUS))
            |-> (chars.position == '0)
    ) else $error("sign character away from the first column");

    // Columns past the decimal width only come from binary text
    a_binary_tail : assert property (
        @(posedge clk) disable iff (!rst_n)
        chars.valid && (chars.position > 4'(i2a_pkg::DEC_DIGITS))
            |-> ((chars.char_code == i2a_pkg::ASCII_ZERO) ||
                 (chars.char_code == i2a_pkg::ASCII_ONE))
    ) else $error("non-binary character beyond the decimal width");

    // The first pipeline stage holds every number it takes
    a_prep_load : assert property (
        @(posedge clk) disable iff (!rst_n)
        number.valid && number.ready |=> st_valid[0]
    ) else $error("accepted number lost at the first stage");

endmodule

// ===== sim/tb_integer_to_ascii_digits.sv =====
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_digits
// Self-checking testbench for the integer-to-ASCII digit formatter. Numbers
// are pushed through the number channel and every character that comes out is
// checked against a local predictor. The run covers directed corner cases,
// random items with random idling on both sides, a long output hold-off that
// fills the block, and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_digits;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 300;

    // One expected or observed character
    typedef struct packed {
        logic [i2a_pkg::CHAR_W-1:0] char_code;
        logic [i2a_pkg::POS_W-1:0]  position;
        logic                       last;
    } char_item_t;

    logic clk;
    logic rst_n;

    i2a_in_if  number_if ();
    i2a_out_if chars_if ();

    integer_to_ascii_digits dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .chars  (chars_if)
    );

    char_item_t expected_chars[$];

    int  mismatch_count;
    int  numbers_taken;
    int  chars_checked;
    int  cycle_count;
    bit  sender_idle;
    bit  receiver_idle;
    int  hold_request;

    // ------------------------------------------------------------------------
    // Predictor: append the characters one number should produce
    // ------------------------------------------------------------------------
    function automatic void predict_characters(input i2a_pkg::mode_t m,
                                               input logic [31:0] v,
                                               input logic [i2a_pkg::LEN_W-1:0] len_in);
        int unsigned     max_digits;
        int unsigned     digits;
        int unsigned     first_col;
        int unsigned     idx;
        logic [31:0]     magnitude;
        longint unsigned scaled;
        logic [3:0]      digit;
        char_item_t      c;
        case (m)
            i2a_pkg::MODE_HEX: max_digits = i2a_pkg::HEX_DIGITS;
            i2a_pkg::MODE_BIN: max_digits = i2a_pkg::BIN_DIGITS;
            default:           max_digits = i2a_pkg::DEC_DIGITS;
        endcase
        digits    = (len_in > max_digits) ? max_digits : len_in;
        magnitude = v;
        first_col = 0;
        // Emit the sign first and format the magnitude after it
        if (m == i2a_pkg::MODE_SDEC)
        begin
            c.char_code = v[31] ? i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_PLUS;
            c.position  = '0;
            c.last      = (digits == 0);
            expected_chars.push_back(c);
            if (v[31])
            begin
                magnitude = 32'd0 - v;
            end
            first_col = 1;
        end
        for (int unsigned i = 0; i < digits; i++)
        begin
            idx = digits - 1 - i;
            case (m)
                i2a_pkg::MODE_HEX: digit = 4'((magnitude >> (4 * idx)) & 32'hF);
                i2a_pkg::MODE_BIN: digit = 4'((magnitude >> idx) & 32'h1);
                default:
                begin
                    scaled = magnitude;
                    for (int unsigned k = 0; k < idx; k++)
                    begin
                        scaled = scaled / 10;
                    end
                    digit = 4'(scaled % 10);
                end
            endcase
            if (digit < 4'd10)
            begin
                c.char_code = i2a_pkg::ASCII_ZERO + i2a_pkg::CHAR_W'(digit);
            end
            else
            begin
                c.char_code = i2a_pkg::ASCII_A + i2a_pkg::CHAR_W'(digit - 4'd10);
            end
            c.position = i2a_pkg::POS_W'(first_col + i);
            c.last     = (i + 1 == digits);
            expected_chars.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
    end

    // Abort the run if it exceeds the cycle budget
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d characters still outstanding",
                 cycle_count, expected_chars.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input monitor: predict every accepted number
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && number_if.valid && number_if.ready)
        begin
            predict_characters(i2a_pkg::mode_t'(number_if.mode), number_if.value,
                               number_if.length);
            numbers_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: compare each accepted character with the oldest one due
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_item_t got;
        char_item_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            got.char_code = chars_if.char_code;
            got.position  = chars_if.position;
            got.last      = chars_if.last;
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("Unexpected character: code %h pos %0d last %0b",
                             got.char_code, got.position, got.last);
                end
            end
            else
            begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("Mismatch: expected code %h pos %0d last %0b,",
                                 want.char_code, want.position, want.last,
                                 " got code %h pos %0d last %0b",
                                 got.char_code, got.position, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, long hold-offs on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left      = 0;
        stall_left     = 0;
        chars_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                chars_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                chars_if.ready <= 1'b0;
                stall_left--;
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                chars_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: offer one number and hold it until the block takes it
    // ------------------------------------------------------------------------
    task automatic send_number(input i2a_pkg::mode_t m, input logic [31:0] v,
                               input logic [i2a_pkg::LEN_W-1:0] len_in);
        int gap;
        @(negedge clk);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            number_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_if.valid  <= 1'b1;
        number_if.mode   <= m;
        number_if.value  <= v;
        number_if.length <= len_in;
        do
        begin
            @(posedge clk);
        end
        while (!number_if.ready);
    endtask

    task automatic release_input();
        @(negedge clk);
        number_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 999));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [i2a_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return '0;
        end
        else if (r <= 2)
        begin
            return i2a_pkg::LEN_W'($urandom_range(17, 31));
        end
        return i2a_pkg::LEN_W'($urandom_range(1, 16));
    endfunction

    task automatic send_random_numbers(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_number(i2a_pkg::mode_t'($urandom_range(0, 3)), pick_value(), pick_length());
        end
    endtask

    // Wait until every predicted character has arrived, then a little longer
    task automatic wait_for_drain();
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_decimal_extremes();
        send_number(i2a_pkg::MODE_UDEC, 32'h0000_0000, 5'd10);
        send_number(i2a_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd10);
        send_number(i2a_pkg::MODE_UDEC, 32'd1234567890, 5'd16);
        send_number(i2a_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd3);
        send_number(i2a_pkg::MODE_UDEC, 32'd42, 5'd0);
    endtask

    task automatic test_signed_cases();
        send_number(i2a_pkg::MODE_SDEC, 32'h0000_0000, 5'd10);
        send_number(i2a_pkg::MODE_SDEC, 32'h8000_0000, 5'd10);
        send_number(i2a_pkg::MODE_SDEC, 32'hFFFF_FFFF, 5'd1);
        send_number(i2a_pkg::MODE_SDEC, 32'h7FFF_FFFF, 5'd10);
        send_number(i2a_pkg::MODE_SDEC, 32'hFFFF_FF85, 5'd0);
        send_number(i2a_pkg::MODE_SDEC, 32'h0000_0007, 5'd0);
        send_number(i2a_pkg::MODE_SDEC, 32'h8000_0001, 5'd31);
    endtask

    task automatic test_hex_and_binary();
        send_number(i2a_pkg::MODE_HEX, 32'hDEAD_BEEF, 5'd8);
        send_number(i2a_pkg::MODE_HEX, 32'h0123_ABCD, 5'd16);
        send_number(i2a_pkg::MODE_HEX, 32'hFFFF_FFFF, 5'd1);
        send_number(i2a_pkg::MODE_HEX, 32'h1234_5678, 5'd0);
        send_number(i2a_pkg::MODE_BIN, 32'hAAAA_5555, 5'd16);
        send_number(i2a_pkg::MODE_BIN, 32'hFFFF_FFFF, 5'd31);
        send_number(i2a_pkg::MODE_BIN, 32'h0000_0000, 5'd1);
        send_number(i2a_pkg::MODE_BIN, 32'h0000_0001, 5'd0);
    endtask

    task automatic test_random_mixed();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        send_random_numbers(150);
    endtask

    // Hold the output off while numbers keep coming so the input stalls
    task automatic test_output_backpressure();
        sender_idle   = 1'b0;
        hold_request  = HOLD_CYCLES;
        send_random_numbers(24);
        release_input();
        wait_for_drain();
    endtask

    task automatic test_streaming_no_idle();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        send_random_numbers(40);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count   = 0;
        numbers_taken    = 0;
        chars_checked    = 0;
        sender_idle      = 1'b1;
        receiver_idle    = 1'b1;
        hold_request     = 0;
        number_if.valid  = 1'b0;
        number_if.mode   = '0;
        number_if.value  = '0;
        number_if.length = '0;

        wait (rst_n === 1'b1);
        test_decimal_extremes();
        test_signed_cases();
        test_hex_and_binary();
        test_random_mixed();
        release_input();
        test_output_backpressure();
        test_streaming_no_idle();
        release_input();
        wait_for_drain();

        mismatch_count += expected_chars.size();
        $display("Formatted %0d numbers into %0d checked characters over all four modes,",
                 numbers_taken, chars_checked);
        $display("lengths 0 to 31, random idling, a %0d-cycle output hold and %0d errors.",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
